>>> hdl/tcli_pkg.sv
package tcli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int VAL_W       = 16;
    localparam int X_W         = 16;
    localparam int LEN_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Scaled position numerator (x - min) * (len - 1), before the fraction shift.
    localparam int NUM_W     = X_W + ADDR_W;
    // Quotient holds the table index above the fraction.
    localparam int Q_W       = ADDR_W + FRAC_BITS;
    localparam int DIV_STEPS = Q_W;
    localparam int PROD_W    = FRAC_BITS + VAL_W + 2;

    localparam logic [LEN_W-1:0]        TABLE_LENGTH_RESET = LEN_W'(2);
    localparam logic signed [X_W-1:0]   RANGE_MIN_RESET    = X_W'(0);
    localparam logic signed [X_W-1:0]   RANGE_MAX_RESET    = X_W'(127);

    typedef enum logic [0:0] {
        FUNC_WRITE = 1'b0,
        FUNC_EVAL  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LENGTH = 2'd0,
        CFG_RANGE_MIN    = 2'd1,
        CFG_RANGE_MAX    = 2'd2
    } t_cfg_idx;

    // Per-item information that travels alongside the divider.
    typedef struct packed {
        logic              eval;
        logic              bypass;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] lm1;
        logic [ADDR_W-1:0] widx;
        logic [VAL_W-1:0]  wval;
    } t_side;

endpackage

>>> hdl/tcli_if.sv
interface tcli_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic signed [tcli_pkg::X_W-1:0]      x;
    logic [tcli_pkg::ADDR_W-1:0]          entry_index;
    logic signed [tcli_pkg::VAL_W-1:0]    entry_value;

    modport source (output valid, func, x, entry_index, entry_value, input ready);
    modport sink   (input valid, func, x, entry_index, entry_value, output ready);
endinterface

interface tcli_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tcli_pkg::VAL_W-1:0]    y;

    modport source (output valid, y, input ready);
    modport sink   (input valid, y, output ready);
endinterface

interface tcli_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcli_pkg::CFG_IDX_W-1:0]       index;
    logic [tcli_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/table_curve_linear_interpolator.sv
// Stages: an evaluate transaction passes the entry stage, 22 divider stages, the
// table read, the multiply and the output register. Throughput: one transaction
// per cycle while the output is not stalled, set by the fully pipelined divider
// and the dual-read curve memory; writes pass down the pipeline and give no result.
// Reset: synchronous, active low; clears pipeline valids and restores the
// configuration registers. Curve memory is not cleared and must be written first.
module table_curve_linear_interpolator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcli_in_if.sink    i_in,
    tcli_out_if.source o_out,
    tcli_cfg_if.sink   i_cfg
);
    import tcli_pkg::*;

    // Configuration registers.
    logic [LEN_W-1:0]      r_table_length;
    logic signed [X_W-1:0] r_range_min;
    logic signed [X_W-1:0] r_range_max;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= TABLE_LENGTH_RESET;
            r_range_min    <= RANGE_MIN_RESET;
            r_range_max    <= RANGE_MAX_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_TABLE_LENGTH: r_table_length <= i_cfg.data[LEN_W-1:0];
                CFG_RANGE_MIN:    r_range_min    <= $signed(i_cfg.data[X_W-1:0]);
                CFG_RANGE_MAX:    r_range_max    <= $signed(i_cfg.data[X_W-1:0]);
                default: ;
            endcase
        end
    end

    // Pipeline advance. The output register holds while the sink stalls, but the
    // stages behind it keep moving whenever the last stage carries no result.
    logic r_out_valid;
    logic r_p_vld;
    logic w_out_en;
    logic w_en;

    assign w_out_en   = !r_out_valid || o_out.ready;
    assign w_en       = w_out_en || !r_p_vld;
    assign i_in.ready = w_en;

    // Entry stage: range checks and numerator.
    logic [LEN_W-1:0]  w_len_m1;
    logic [ADDR_W-1:0] w_lm1;
    logic [X_W:0]      w_d_full;
    logic [X_W:0]      w_s_full;
    logic [NUM_W-1:0]  w_num;
    logic [NUM_W-1:0]  n_num;
    logic [X_W-1:0]    n_den;
    t_side             n_side;

    assign w_len_m1 = r_table_length - LEN_W'(1);
    assign w_d_full = {i_in.x[X_W-1], i_in.x} - {r_range_min[X_W-1], r_range_min};
    assign w_s_full = {r_range_max[X_W-1], r_range_max} - {r_range_min[X_W-1], r_range_min};
    assign w_num    = {{ADDR_W{1'b0}}, w_d_full[X_W-1:0]} * {{X_W{1'b0}}, w_lm1};

    always_comb begin
        // A length of zero counts as one; lengths beyond the table saturate.
        priority if (r_table_length == '0) begin
            w_lm1 = '0;
        end else if (r_table_length > LEN_W'(TABLE_DEPTH)) begin
            w_lm1 = ADDR_W'(TABLE_DEPTH - 1);
        end else begin
            w_lm1 = w_len_m1[ADDR_W-1:0];
        end
    end

    always_comb begin
        n_side.eval   = (i_in.func == FUNC_EVAL);
        n_side.lm1    = w_lm1;
        n_side.widx   = i_in.entry_index;
        n_side.wval   = i_in.entry_value;
        n_side.bypass = 1'b1;
        n_side.addr   = '0;
        n_num         = '0;
        n_den         = X_W'(1);
        priority if (w_lm1 == '0) begin
            n_side.addr = '0;
        end else if (i_in.x < r_range_min) begin
            n_side.addr = '0;
        end else if (i_in.x > r_range_max) begin
            n_side.addr = w_lm1;
        end else if (r_range_max <= r_range_min) begin
            n_side.addr = '0;
        end else begin
            n_side.bypass = 1'b0;
            n_num         = w_num;
            n_den         = w_s_full[X_W-1:0];
        end
    end

    logic             r_s0_vld;
    logic [NUM_W-1:0] r_s0_num;
    logic [X_W-1:0]   r_s0_den;
    t_side            r_s0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_num  <= n_num;
            r_s0_den  <= n_den;
            r_s0_side <= n_side;
        end
    end

    logic             w_dv;
    logic [Q_W-1:0]   w_quo;
    t_side            w_dside;

    tcli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_num   (r_s0_num),
        .i_den   (r_s0_den),
        .i_side  (r_s0_side),
        .o_vld   (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    // Table addresses from the quotient. Direct cases read one entry with zero fraction.
    logic [ADDR_W-1:0]    w_qidx;
    logic [ADDR_W-1:0]    w_addr_a;
    logic [ADDR_W-1:0]    w_addr_b;
    logic [FRAC_BITS-1:0] w_frac;

    assign w_qidx = w_quo[Q_W-1:FRAC_BITS];

    always_comb begin
        priority if (w_dside.bypass) begin
            w_addr_a = w_dside.addr;
            w_frac   = '0;
        end else if (w_qidx >= w_dside.lm1) begin
            w_addr_a = w_dside.lm1;
            w_frac   = '0;
        end else begin
            w_addr_a = w_qidx;
            w_frac   = w_quo[FRAC_BITS-1:0];
        end
    end

    assign w_addr_b = w_addr_a + ADDR_W'(1);

    // Curve memory. Writes reach it at the same stage where evaluates read it,
    // so every access sees the table exactly as transaction order leaves it.
    logic [VAL_W-1:0]     r_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]     r_rd_a;
    logic [VAL_W-1:0]     r_rd_b;
    logic [FRAC_BITS-1:0] r_m_frac;
    logic                 r_m_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dv && !w_dside.eval) begin
                r_mem[w_dside.widx] <= w_dside.wval;
            end
            r_rd_a   <= r_mem[w_addr_a];
            r_rd_b   <= r_mem[w_addr_b];
            r_m_frac <= w_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_p_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= w_dv && w_dside.eval;
            r_p_vld <= r_m_vld;
        end
    end

    // Multiply stage.
    logic signed [VAL_W:0]    w_diff;
    logic signed [PROD_W-1:0] r_p_prod;
    logic [VAL_W-1:0]         r_p_a;

    assign w_diff = $signed({r_rd_b[VAL_W-1], r_rd_b}) - $signed({r_rd_a[VAL_W-1], r_rd_a});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_prod <= $signed({1'b0, r_m_frac}) * w_diff;
            r_p_a    <= r_rd_a;
        end
    end

    // Floor of the weighted step is an arithmetic shift; the sum stays inside the
    // two neighboring points, so its low bits are the result.
    logic signed [PROD_W-1:0] w_p_sh;
    logic [VAL_W:0]           w_sum;
    logic [VAL_W-1:0]         r_y;

    assign w_p_sh = r_p_prod >>> FRAC_BITS;
    assign w_sum  = {r_p_a[VAL_W-1], r_p_a} + w_p_sh[VAL_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_y <= w_sum[VAL_W-1:0];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.y     = $signed(r_y);

endmodule

>>> hdl/tcli_div.sv
module tcli_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [tcli_pkg::NUM_W-1:0]   i_num,
    input  logic [tcli_pkg::X_W-1:0]     i_den,
    input  tcli_pkg::t_side              i_side,
    output logic                         o_vld,
    output logic [tcli_pkg::Q_W-1:0]     o_quo,
    output tcli_pkg::t_side              o_side
);
    import tcli_pkg::*;

    // One quotient bit per stage, restoring division of (num << FRAC_BITS) by den.
    logic [X_W-1:0] r_rem  [DIV_STEPS];
    logic [Q_W-1:0] r_num  [DIV_STEPS];
    logic [Q_W-1:0] r_quo  [DIV_STEPS];
    logic [X_W-1:0] r_den  [DIV_STEPS];
    t_side          r_side [DIV_STEPS];
    logic           r_vld  [DIV_STEPS];

    logic [X_W-1:0] n_rem  [DIV_STEPS];
    logic [Q_W-1:0] n_num  [DIV_STEPS];
    logic [Q_W-1:0] n_quo  [DIV_STEPS];

    always_comb begin
        logic [X_W-1:0] src_rem;
        logic [Q_W-1:0] src_num;
        logic [Q_W-1:0] src_quo;
        logic [X_W-1:0] src_den;
        logic [X_W:0]   trial;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (j == 0) begin
                // The quotient is known to fit in Q_W bits, so the top bits start below den.
                src_rem = i_num[NUM_W-1 -: X_W];
                src_num = {i_num[ADDR_W-1:0], {FRAC_BITS{1'b0}}};
                src_quo = '0;
                src_den = i_den;
            end else begin
                src_rem = r_rem[j-1];
                src_num = r_num[j-1];
                src_quo = r_quo[j-1];
                src_den = r_den[j-1];
            end
            trial = {src_rem, src_num[Q_W-1]} - {1'b0, src_den};
            if (!trial[X_W]) begin
                n_rem[j] = trial[X_W-1:0];
                n_quo[j] = {src_quo[Q_W-2:0], 1'b1};
            end else begin
                n_rem[j] = {src_rem[X_W-2:0], src_num[Q_W-1]};
                n_quo[j] = {src_quo[Q_W-2:0], 1'b0};
            end
            n_num[j] = {src_num[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r_rem[j] <= n_rem[j];
                r_num[j] <= n_num[j];
                r_quo[j] <= n_quo[j];
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int j = 1; j < DIV_STEPS; j++) begin
                r_den[j]  <= r_den[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_quo  = r_quo[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

>>> bench/tb_table_curve_linear_interpolator.sv
module tb_table_curve_linear_interpolator;
    import tcli_pkg::*;

    localparam int PIPE_LATENCY = 25;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 177;
    localparam int IDLE_PCT     = 22;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_EVAL,
        ROW_CFG
    } t_row_kind;

    // The word is the position for an evaluation, the point value for a write
    // and the register data for a configuration row.
    typedef struct {
        t_row_kind          kind;
        t_cfg_idx           reg_idx;
        logic [15:0]        word;
        logic [ADDR_W-1:0]  idx;
        logic               typed;
        logic signed [15:0] y;
    } t_stim_row;

    localparam int N_ROWS = 28;

    t_stim_row directed_rows [N_ROWS] = '{
        '{ROW_WRITE, CFG_TABLE_LENGTH, 16'h8000, 6'd0,  1'b0, 16'sh0000},
        '{ROW_WRITE, CFG_TABLE_LENGTH, 16'h7FFF, 6'd1,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'h8000, 6'd0,  1'b1, 16'sh8000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'h7FFF, 6'd0,  1'b1, 16'sh7FFF},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd127,  6'd0,  1'b1, 16'sh7FFF},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd0,    6'd0,  1'b1, 16'sh8000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd64,   6'd0,  1'b0, 16'sh0000},
        '{ROW_WRITE, CFG_TABLE_LENGTH, 16'h1234, 6'd63, 1'b0, 16'sh0000},
        '{ROW_CFG,   CFG_TABLE_LENGTH, 16'd64,   6'd0,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd127,  6'd0,  1'b1, 16'sh1234},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd100,  6'd0,  1'b0, 16'sh0000},
        '{ROW_CFG,   CFG_RANGE_MIN,    16'h8000, 6'd0,  1'b0, 16'sh0000},
        '{ROW_CFG,   CFG_RANGE_MAX,    16'h7FFF, 6'd0,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'h8000, 6'd0,  1'b1, 16'sh8000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'h7FFF, 6'd0,  1'b1, 16'sh1234},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd0,    6'd0,  1'b0, 16'sh0000},
        '{ROW_CFG,   CFG_TABLE_LENGTH, 16'd1,    6'd0,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd5000, 6'd0,  1'b1, 16'sh8000},
        '{ROW_CFG,   CFG_TABLE_LENGTH, 16'd0,    6'd0,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd100,  6'd0,  1'b1, 16'sh8000},
        '{ROW_CFG,   CFG_TABLE_LENGTH, 16'd127,  6'd0,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'h7FFF, 6'd0,  1'b1, 16'sh1234},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd1,    6'd0,  1'b0, 16'sh0000},
        '{ROW_CFG,   CFG_RANGE_MAX,    16'h8000, 6'd0,  1'b0, 16'sh0000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'h8000, 6'd0,  1'b1, 16'sh8000},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'd0,    6'd0,  1'b1, 16'sh1234},
        '{ROW_EVAL,  CFG_TABLE_LENGTH, 16'hFFFF, 6'd0,  1'b1, 16'sh1234},
        '{ROW_WRITE, CFG_TABLE_LENGTH, 16'h00FF, 6'd32, 1'b0, 16'sh0000}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcli_in_if  in_if();
    tcli_out_if out_if();
    tcli_cfg_if cfg_if();

    table_curve_linear_interpolator i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // Shadow of the block: curve points and configuration.
    logic signed [VAL_W-1:0] curve_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]        cur_len = TABLE_LENGTH_RESET;
    logic signed [X_W-1:0]   cur_min = RANGE_MIN_RESET;
    logic signed [X_W-1:0]   cur_max = RANGE_MAX_RESET;

    logic signed [VAL_W-1:0] expected_y [$];
    logic signed [VAL_W-1:0] want_y;
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    bit                      steady = 1'b0;

    always #4 i_clk = ~i_clk;

    function automatic logic signed [VAL_W-1:0] interp_curve(logic signed [X_W-1:0] pos);
        int     len;
        int     seg;
        longint d;
        longint span;
        longint q;
        longint f;
        longint a;
        longint b;
        len = int'(cur_len);
        if (len == 0) len = 1;
        if (len > TABLE_DEPTH) len = TABLE_DEPTH;
        if (len == 1 || pos < cur_min) return curve_mem[0];
        if (pos > cur_max) return curve_mem[len-1];
        if (cur_max <= cur_min) return curve_mem[0];
        d    = longint'(pos) - longint'(cur_min);
        span = longint'(cur_max) - longint'(cur_min);
        q    = ((d * (len - 1)) <<< FRAC_BITS) / span;
        seg  = int'(q >>> FRAC_BITS);
        f    = q & ((longint'(1) <<< FRAC_BITS) - 1);
        if (seg >= len - 1) return curve_mem[len-1];
        a = curve_mem[seg];
        b = curve_mem[seg+1];
        // Arithmetic shift of a signed product floors toward minus infinity.
        return VAL_W'(a + ((f * (b - a)) >>> FRAC_BITS));
    endfunction

    // Entered and left at a falling edge.
    task automatic send_item(t_func fn, logic signed [X_W-1:0] pos, logic [ADDR_W-1:0] idx,
                             logic signed [VAL_W-1:0] val, logic typed,
                             logic signed [VAL_W-1:0] typed_y);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.func        <= fn;
        in_if.x           <= pos;
        in_if.entry_index <= idx;
        in_if.entry_value <= val;
        do @(posedge i_clk); while (!in_if.ready);
        if (fn == FUNC_WRITE) begin
            curve_mem[idx] = val;
        end else begin
            expected_y.push_back(typed ? typed_y : interp_curve(pos));
        end
        @(negedge i_clk);
    endtask

    // Writes give no result, so a write may still be in flight when the queue
    // runs empty; the extra cycles cover the whole pipeline.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (expected_y.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx ri, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= ri;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (ri)
            CFG_TABLE_LENGTH: cur_len = data[LEN_W-1:0];
            CFG_RANGE_MIN:    cur_min = data;
            CFG_RANGE_MAX:    cur_max = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_y.size() == 0) begin
                $error("y: no result expected, actual %0d", out_if.y);
                mismatch_count++;
            end else begin
                want_y = expected_y.pop_front();
                if (out_if.y !== want_y) begin
                    $error("y mismatch: expected %0d, actual %0d", want_y, out_if.y);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL table_curve_linear_interpolator");
        $finish;
    end

    initial begin
        int                      phase;
        int                      n;
        int                      lo;
        int                      hi;
        int                      tmp;
        logic signed [X_W-1:0]   pos;
        logic signed [VAL_W-1:0] val;
        logic [LEN_W-1:0]        len;

        in_if.valid       = 1'b0;
        in_if.func        = FUNC_WRITE;
        in_if.x           = '0;
        in_if.entry_index = '0;
        in_if.entry_value = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_TABLE_LENGTH;
        cfg_if.data       = '0;
        out_if.ready      = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The curve memory comes up undefined, so every point is loaded first.
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            send_item(FUNC_WRITE, X_W'($urandom), ADDR_W'(k), VAL_W'($urandom), 1'b0, '0);
        end

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CFG: begin
                    wait_idle();
                    write_reg(directed_rows[r].reg_idx, directed_rows[r].word);
                end
                ROW_WRITE: begin
                    send_item(FUNC_WRITE, X_W'($urandom), directed_rows[r].idx,
                              directed_rows[r].word, 1'b0, '0);
                end
                default: begin
                    send_item(FUNC_EVAL, directed_rows[r].word, ADDR_W'($urandom),
                              VAL_W'($urandom), directed_rows[r].typed, directed_rows[r].y);
                end
            endcase
        end

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       len = LEN_W'(1);
                1:       len = LEN_W'(64);
                2:       len = LEN_W'(0);
                3:       len = LEN_W'(127);
                4:       len = LEN_W'(2);
                default: len = LEN_W'($urandom_range(3, 64));
            endcase
            lo = $signed(16'($urandom));
            hi = $signed(16'($urandom));
            case ($urandom_range(0, 5))
                0: begin
                    lo = -32768;
                    hi = 32767;
                end
                1: begin
                    lo = 0;
                    hi = 127;
                end
                2: begin
                    hi = lo + int'($urandom_range(1, 300));
                    if (hi > 32767) hi = 32767;
                end
                3: begin
                    if (hi > lo) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
                default: begin
                    if (hi < lo) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
            endcase
            if (phase == 0) begin
                len = LEN_W'(64);
                lo  = -32768;
                hi  = 32767;
            end
            steady = (phase == 4);
            write_reg(CFG_TABLE_LENGTH, CFG_DATA_W'(len));
            write_reg(CFG_RANGE_MIN, CFG_DATA_W'(lo));
            write_reg(CFG_RANGE_MAX, CFG_DATA_W'(hi));

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 20) begin
                    case ($urandom_range(0, 7))
                        0:       val = 16'sh8000;
                        1:       val = 16'sh7FFF;
                        default: val = VAL_W'($urandom);
                    endcase
                    send_item(FUNC_WRITE, X_W'($urandom), ADDR_W'($urandom), val, 1'b0, '0);
                end else begin
                    tmp = $urandom_range(0, 99);
                    if (tmp < 45 && cur_min < cur_max) begin
                        pos = X_W'(int'(cur_min) +
                                   int'($urandom_range(0, int'(cur_max) - int'(cur_min))));
                    end else if (tmp < 60) begin
                        case ($urandom_range(0, 5))
                            0:       pos = cur_min;
                            1:       pos = cur_max;
                            2:       pos = cur_min - 16'sd1;
                            3:       pos = cur_max + 16'sd1;
                            4:       pos = cur_min + 16'sd1;
                            default: pos = cur_max - 16'sd1;
                        endcase
                    end else begin
                        pos = X_W'($urandom);
                    end
                    send_item(FUNC_EVAL, pos, ADDR_W'($urandom), VAL_W'($urandom), 1'b0, '0);
                end
            end
        end

        steady = 1'b0;
        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS table_curve_linear_interpolator");
        end else begin
            $display("FAIL table_curve_linear_interpolator");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tcli_pkg.sv
hdl/tcli_if.sv
hdl/tcli_div.sv
hdl/table_curve_linear_interpolator.sv
bench/tb_table_curve_linear_interpolator.sv
